// ===== rtl/core/irw_pkg.sv =====
`timescale 1ns / 1ps

package irw_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int THRESH_W    = 16;
  localparam int NUM_SENSORS = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1300;

  // command field codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_DIR    = 2'd1;
  localparam logic [1:0] CMD_SIDE   = 2'd2;

  // event_code values
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_BLOCKED = 2'd1;
  localparam logic [1:0] EV_CLEARED = 2'd2;

  typedef logic [1:0] sensor_t;

  localparam sensor_t SENSOR_0 = 2'd0;
  localparam sensor_t SENSOR_1 = 2'd1;
  localparam sensor_t SENSOR_2 = 2'd2;
  localparam sensor_t SENSOR_3 = 2'd3;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_DIR,
    OP_SIDE,
    OP_NOP
  } op_t;

  // one classified item waiting for the back end
  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] second_sample;
    sensor_t             sel_a;
    sensor_t             sel_b;
  } entry_t;

  // back end status seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

// ===== rtl/core/irw_ram.sv =====
`timescale 1ns / 1ps

module irw_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/irw_front.sv =====
`timescale 1ns / 1ps

module irw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [9:0]           in_first_converter_value,
  input  logic                 in_first_converter_done,
  input  logic [9:0]           in_second_converter_value,
  input  logic                 in_second_converter_done,
  input  logic                 in_direction,
  input  logic                 in_side,
  input  irw_pkg::back_stat_t  bstat,
  output logic                 q_valid,
  output irw_pkg::entry_t      q_entry
);

  import irw_pkg::*;

  entry_t     q_r [QUEUE_DEPTH];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  entry_t     cls;
  logic       push;
  logic       full;

  // classify the incoming item
  always_comb begin
    cls.first_sample  = in_first_converter_done  ? in_first_converter_value  : '0;
    cls.second_sample = in_second_converter_done ? in_second_converter_value : '0;
    cls.sel_a         = in_direction ? SENSOR_3 : SENSOR_0;
    cls.sel_b         = in_direction ? SENSOR_2 : SENSOR_1;
    case (in_command)
      CMD_SAMPLE: cls.op = OP_SAMPLE;
      CMD_DIR:    cls.op = OP_DIR;
      CMD_SIDE: begin
        cls.op = OP_SIDE;
        if (in_direction) begin
          cls.sel_a = in_side ? SENSOR_2 : SENSOR_3;
        end else begin
          cls.sel_a = in_side ? SENSOR_0 : SENSOR_1;
        end
        cls.sel_b = cls.sel_a;
      end
      default:    cls.op = OP_NOP;
    endcase
  end

  assign full     = (cnt_r == 2'(QUEUE_DEPTH));
  assign in_stall = full || bstat.clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (bstat.pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, bstat.pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/irw_back.sv =====
`timescale 1ns / 1ps

module irw_back #(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  irw_pkg::entry_t      q_entry,
  output irw_pkg::back_stat_t  bstat,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_code,
  output logic                 out_obstacle_seen
);

  import irw_pkg::*;

  localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SW    = $clog2(WINDOW_DEPTH * 1023 + 1);
  localparam int CMP_W = (SW > THRESH_W) ? SW : THRESH_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_EVAL,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_r;
  logic [AW-1:0]       slot_r;
  logic                phase_r;
  logic                latch_r;
  logic [THRESH_W-1:0] thr_r;
  op_t                 op_r;
  sensor_t             sel_a_r;
  sensor_t             sel_b_r;
  logic [CW-1:0]       cnt_r;
  logic [SW-1:0]       acc_a_r;
  logic [SW-1:0]       acc_b_r;
  logic [1:0]          res_event_r;
  logic                res_seen_r;
  logic                out_valid_r;
  logic [1:0]          out_event_r;
  logic                out_seen_r;

  logic [NUM_SENSORS-1:0] ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_W-1:0]    ram_wdata [NUM_SENSORS];
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_W-1:0]    rd_data   [NUM_SENSORS];
  logic                   pop;
  logic                   hit_a;
  logic                   hit_b;
  logic                   hit;

  assign pop            = (state_r == S_IDLE) && q_valid;
  assign bstat.pop      = pop;
  assign bstat.clearing = (state_r == S_CLEAR);

  // window store write and read control
  always_comb begin
    ram_we    = '0;
    ram_waddr = slot_r;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      ram_wdata[s] = (s < 2) ? q_entry.first_sample : q_entry.second_sample;
    end
    if (state_r == S_CLEAR) begin
      ram_we    = '1;
      ram_waddr = clr_r;
      for (int s = 0; s < NUM_SENSORS; s++) begin
        ram_wdata[s] = '0;
      end
    end else if (pop && (q_entry.op == OP_SAMPLE)) begin
      // phase 0 feeds sensors 0 and 2, phase 1 sensors 1 and 3
      if (phase_r) begin
        ram_we[SENSOR_1] = 1'b1;
        ram_we[SENSOR_3] = 1'b1;
      end else begin
        ram_we[SENSOR_0] = 1'b1;
        ram_we[SENSOR_2] = 1'b1;
      end
    end
    ram_raddr = (cnt_r < CW'(WINDOW_DEPTH)) ? cnt_r[AW-1:0] : '0;
  end

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_win
    irw_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata[g]),
      .raddr (ram_raddr),
      .rdata (rd_data[g])
    );
  end

  assign hit_a = CMP_W'(acc_a_r) > CMP_W'(thr_r);
  assign hit_b = CMP_W'(acc_b_r) > CMP_W'(thr_r);
  assign hit   = hit_a || hit_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      slot_r      <= '0;
      phase_r     <= 1'b0;
      latch_r     <= 1'b0;
      thr_r       <= THRESH_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      // S_DONE owns out_valid_r while it waits to load
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(WINDOW_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            op_r        <= q_entry.op;
            sel_a_r     <= q_entry.sel_a;
            sel_b_r     <= q_entry.sel_b;
            res_event_r <= EV_NONE;
            res_seen_r  <= 1'b0;
            cnt_r       <= '0;
            acc_a_r     <= '0;
            acc_b_r     <= '0;
            case (q_entry.op)
              OP_SAMPLE: begin
                phase_r <= ~phase_r;
                if (phase_r) begin
                  slot_r <= (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + AW'(1);
                end
                state_r <= S_DONE;
              end
              OP_DIR, OP_SIDE: state_r <= S_SUM;
              default:         state_r <= S_DONE;
            endcase
          end
        end
        S_SUM: begin
          // the store read is registered, so read data lags the address
          if (cnt_r != '0) begin
            acc_a_r <= acc_a_r + SW'(rd_data[sel_a_r]);
            acc_b_r <= acc_b_r + SW'(rd_data[sel_b_r]);
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(WINDOW_DEPTH)) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_seen_r <= hit;
          if (op_r == OP_DIR) begin
            if (hit && !latch_r) begin
              latch_r     <= 1'b1;
              res_event_r <= EV_BLOCKED;
            end else if (!hit && latch_r) begin
              latch_r     <= 1'b0;
              res_event_r <= EV_CLEARED;
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_event_r <= res_event_r;
            out_seen_r  <= res_seen_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_event_r;
  assign out_obstacle_seen = out_seen_r;

endmodule

// ===== rtl/core/ir_range_window_obstacle_detect.sv =====
`timescale 1ns / 1ps
// channel   direction  ports                                       transfer when
// input     in         in_valid, in_stall, in_<field> x7           in_valid & !in_stall
// result    out        out_valid, out_stall, out_event_code/seen   out_valid & !out_stall
// config    in         cfg_we, cfg_wdata[15:0] (threshold)         cfg_we
//
// A sample passes through the queue, one store write and the output load.
// Queries: one read port per window and one adder per summed sensor walk the
//   window one slot a cycle.
// Reset (synchronous, rst_n low) starts a clearing pass over the four window
//   stores; in_stall is high during it.
// A two-entry queue separates input classification from execution, so input
//   transfers continue until the queue fills while a result waits behind out_stall.

module ir_range_window_obstacle_detect #(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_first_converter_value,
  input  logic        in_first_converter_done,
  input  logic [9:0]  in_second_converter_value,
  input  logic        in_second_converter_done,
  input  logic        in_direction,
  input  logic        in_side,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_code,
  output logic        out_obstacle_seen,
  // threshold register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  import irw_pkg::*;

  logic       q_valid;
  entry_t     q_entry;
  back_stat_t bstat;

  // front: accept, classify, queue
  irw_front u_front (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_command                (in_command),
    .in_first_converter_value  (in_first_converter_value),
    .in_first_converter_done   (in_first_converter_done),
    .in_second_converter_value (in_second_converter_value),
    .in_second_converter_done  (in_second_converter_done),
    .in_direction              (in_direction),
    .in_side                   (in_side),
    .bstat                     (bstat),
    .q_valid                   (q_valid),
    .q_entry                   (q_entry)
  );

  // back: window stores, summing, blocked latch, output register
  irw_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .bstat             (bstat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_code    (out_event_code),
    .out_obstacle_seen (out_obstacle_seen)
  );

endmodule
